### rtl/phsi_pkg.sv
// shared types and constants for the plate hash set insert block
// no dependencies; imported by every module of the block
package phsi_pkg;

    localparam int NUM_BUCKETS  = 1024;
    localparam int BUCKET_DEPTH = 4;

    localparam int LETTER_W   = 8;
    localparam int NUMBER_W   = 10;
    localparam int REGION_W   = 10;
    localparam int ENTRY_W    = 3 * LETTER_W + REGION_W;
    localparam int BUCKET_W   = $clog2(NUM_BUCKETS);
    localparam int SLOT_W     = $clog2(BUCKET_DEPTH);
    localparam int COUNT_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int FILL_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 8;

    typedef logic [ENTRY_W-1:0]                   entry_t;
    typedef logic [BUCKET_DEPTH-1:0][ENTRY_W-1:0] row_t;
    typedef logic [COUNT_W-1:0]                   count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_DROPPED   = 2'd2
    } status_t;

    // classified request as it waits in the queue
    typedef struct packed {
        logic                out_of_range;
        logic [BUCKET_W-1:0] bucket;
        entry_t              key;
    } req_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        req_t req;
    } q_head_t;

endpackage

### rtl/phsi_front.sv
// front end: accepts plate requests, builds the key and bucket, holds a two-deep queue
// depends on phsi_pkg
module phsi_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [phsi_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                accept_en,
    output phsi_pkg::q_head_t                   head,
    input  logic                                pop
);
    import phsi_pkg::*;

    localparam int Q_DEPTH = 2;

    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
    logic [NUMBER_W-1:0] plate_number;
    logic [LETTER_W-1:0] third_letter;
    logic [REGION_W-1:0] region_code;
    req_t                req_in;
    logic                push;

    req_t                q_mem_reg [Q_DEPTH];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          fill_reg, fill_next;

    assign first_letter  = s_tdata[7:0];
    assign second_letter = s_tdata[15:8];
    assign plate_number  = s_tdata[25:16];
    assign third_letter  = s_tdata[33:26];
    assign region_code   = s_tdata[43:34];

    always_comb begin
        req_in.out_of_range = ({1'b0, plate_number} >= (NUMBER_W+1)'(NUM_BUCKETS));
        req_in.bucket       = BUCKET_W'(plate_number);
        req_in.key          = {first_letter, second_letter, third_letter, region_code};
    end

    assign s_tready = accept_en && (fill_reg != 2'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;

    assign head.valid = (fill_reg != 2'd0);
    assign head.req   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

### rtl/phsi_back.sv
// back end: bucket and count memories, compare and append, result register
// depends on phsi_pkg
module phsi_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  phsi_pkg::q_head_t                   head,
    output logic                                pop,
    output logic                                accept_en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [phsi_pkg::M_DATA_W-1:0]       m_tdata
);
    import phsi_pkg::*;

    typedef enum logic [2:0] {
        BK_CLEAR = 3'b001,
        BK_ISSUE = 3'b010,
        BK_EXEC  = 3'b100
    } bk_state_t;

    bk_state_t           state_reg, state_next;
    logic [BUCKET_W-1:0] clr_idx_reg, clr_idx_next;
    req_t                cur_reg, cur_next;

    row_t                ent_mem [NUM_BUCKETS];
    count_t              cnt_mem [NUM_BUCKETS];
    row_t                ent_rd_reg;
    count_t              cnt_rd_reg;

    logic                rd_en;
    logic [BUCKET_W-1:0] rd_addr;
    logic                ent_we;
    row_t                ent_wrow;
    logic                cnt_we;
    logic [BUCKET_W-1:0] cnt_waddr;
    count_t              cnt_wdata;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [FILL_W-1:0]   out_fill_reg, out_fill_next;

    count_t                  cnt_clamped;
    logic [BUCKET_DEPTH-1:0] hit;
    logic                    commit;
    status_t                 res_status;
    count_t                  res_count;

    // compare against the occupied slots of the bucket just read
    always_comb begin
        cnt_clamped = (cnt_rd_reg > COUNT_W'(BUCKET_DEPTH)) ? COUNT_W'(BUCKET_DEPTH)
                                                           : cnt_rd_reg;
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
            hit[i] = (COUNT_W'(i) < cnt_clamped) && (ent_rd_reg[i] == cur_reg.key);
        end
        ent_wrow = ent_rd_reg;
        ent_wrow[cnt_clamped[SLOT_W-1:0]] = cur_reg.key;
        if (cur_reg.out_of_range) begin
            res_status = ST_DROPPED;
            res_count  = '0;
        end else if (|hit) begin
            res_status = ST_DUPLICATE;
            res_count  = cnt_clamped;
        end else if (cnt_clamped < COUNT_W'(BUCKET_DEPTH)) begin
            res_status = ST_INSERTED;
            res_count  = cnt_clamped + COUNT_W'(1);
        end else begin
            res_status = ST_DROPPED;
            res_count  = cnt_clamped;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cur_next     = cur_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head.req.bucket;
        ent_we       = 1'b0;
        cnt_we       = 1'b0;
        cnt_waddr    = cur_reg.bucket;
        cnt_wdata    = res_count;
        commit       = 1'b0;
        unique case (state_reg)
            BK_CLEAR: begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                cnt_wdata    = '0;
                clr_idx_next = clr_idx_reg + BUCKET_W'(1);
                if (clr_idx_reg == BUCKET_W'(NUM_BUCKETS - 1)) begin
                    state_next = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    cur_next   = head.req;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    commit     = 1'b1;
                    ent_we     = (res_status == ST_INSERTED);
                    cnt_we     = (res_status == ST_INSERTED);
                    state_next = BK_ISSUE;
                end
            end
            default: begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        if (commit) begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_fill_next   = FILL_W'(res_count);
        end else if (m_tready) begin
            out_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[cur_reg.bucket] <= ent_wrow;
        end
        if (rd_en) begin
            ent_rd_reg <= ent_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (rd_en) begin
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
    end

    assign accept_en = (state_reg != BK_CLEAR);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - STATUS_W - FILL_W){1'b0}}, out_fill_reg, out_status_reg};

endmodule

### rtl/plate_hash_set_insert_top.sv
// path: an accepted request waits in the queue until the back end issues its bucket and count
// read, then is compared and written to the result register; a request still in the back end,
// older queued requests and a low m_tready delay it; the back end takes one request at a time
// the two-deep queue lets the input keep accepting while a result waits on m_tready
// reset: aresetn is synchronous, active low; afterwards the bucket counters are cleared
// one bucket a cycle, 1024 buckets in all, during which s_tready stays low
module plate_hash_set_insert_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] first_letter, [15:8] second_letter, [25:16] plate_number,
    // [33:26] third_letter, [43:34] region_code, [47:44] zero
    input  logic [phsi_pkg::S_DATA_W-1:0]       s_tdata,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [4:2] bucket_fill, [7:5] zero
    output logic [phsi_pkg::M_DATA_W-1:0]       m_tdata
);
    import phsi_pkg::*;

    // queue head from the front end to the back end
    q_head_t head;
    // back end takes the head request
    logic    pop;
    // low while the counter clearing pass runs
    logic    accept_en;

    // front end: unpacks the request, forms the 34-bit key and the bucket index,
    // flags numbers past the last bucket and queues the request
    phsi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .accept_en (accept_en),
        .head      (head),
        .pop       (pop)
    );

    // back end: reads a bucket row and its count, compares every occupied slot,
    // appends the key if it is new and there is room, then registers the result
    phsi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .accept_en (accept_en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### bench/tb_plate_hash_set_insert_top.sv
// self-checking bench for plate_hash_set_insert_top: bucket set insert with status and fill
// depends on phsi_pkg and the rtl top; holds its own model of the buckets to predict results
module tb_plate_hash_set_insert_top;
    timeunit 1ns;
    timeprecision 1ps;

    import phsi_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOT_COUNT    = 12;
    localparam int RANDOM_ITEMS = 1000;

    // request layout on s_tdata, lowest field at the bottom
    typedef struct packed {
        logic [3:0]          zero;
        logic [REGION_W-1:0] region_code;
        logic [LETTER_W-1:0] third_letter;
        logic [NUMBER_W-1:0] plate_number;
        logic [LETTER_W-1:0] second_letter;
        logic [LETTER_W-1:0] first_letter;
    } plate_t;

    // result layout on m_tdata
    typedef struct packed {
        logic [2:0]        zero;
        logic [FILL_W-1:0] fill;
        status_t           status;
    } verdict_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // bench copy of the set: stored keys and per-bucket fill counters
    entry_t      key_store   [NUM_BUCKETS][BUCKET_DEPTH];
    int unsigned fill_counts [NUM_BUCKETS] = '{default: 0};

    plate_t      plates_to_send[$];
    verdict_t    pending_verdicts[$];
    int unsigned n_total        = 0;
    int unsigned n_sent         = 0;
    int unsigned mismatch_count = 0;
    logic        req_taken      = 1'b0;

    plate_hash_set_insert_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic plate_t make_plate(input int unsigned l1, input int unsigned l2,
                                          input int unsigned num, input int unsigned l3,
                                          input int unsigned region);
        plate_t p;
        p               = '0;
        p.first_letter  = LETTER_W'(l1);
        p.second_letter = LETTER_W'(l2);
        p.plate_number  = NUMBER_W'(num);
        p.third_letter  = LETTER_W'(l3);
        p.region_code   = REGION_W'(region);
        return p;
    endfunction

    // look the plate up in its bucket, append it when new and there is room
    function automatic verdict_t predict_insert(input plate_t p);
        verdict_t    v;
        entry_t      key;
        int unsigned cnt;
        int unsigned b;
        v = '0;
        b = p.plate_number;
        if (b >= NUM_BUCKETS) begin
            v.status = ST_DROPPED;
            return v;
        end
        key = {p.first_letter, p.second_letter, p.third_letter, p.region_code};
        cnt = fill_counts[b];
        if (cnt > BUCKET_DEPTH) begin
            cnt = BUCKET_DEPTH;
        end
        v.status = ST_INSERTED;
        for (int i = 0; i < cnt; i++) begin
            if (key_store[b][i] == key) begin
                v.status = ST_DUPLICATE;
            end
        end
        if (v.status == ST_INSERTED) begin
            if (cnt < BUCKET_DEPTH) begin
                key_store[b][cnt] = key;
                cnt++;
                fill_counts[b] = cnt;
            end else begin
                v.status = ST_DROPPED;
            end
        end
        v.fill = FILL_W'(cnt);
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("%0t ns: %s got %0d want %0d", $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    // stimulus: directed corners first, then a random mix that keeps a few buckets busy
    initial begin
        int unsigned hot [HOT_COUNT];
        int unsigned pick;
        plate_t      p;
        // all-zero plate and one with all-ones letters, number 999 and region 999, each followed by a repeat
        plates_to_send.push_back(make_plate(0, 0, 0, 0, 0));
        plates_to_send.push_back(make_plate(0, 0, 0, 0, 0));
        plates_to_send.push_back(make_plate(255, 255, 999, 255, 999));
        plates_to_send.push_back(make_plate(255, 255, 999, 255, 999));
        // alternating bit patterns so each field bit is seen high and low
        plates_to_send.push_back(make_plate(8'h55, 8'hAA, 10'h155, 8'h55, 10'h2AA));
        plates_to_send.push_back(make_plate(8'hAA, 8'h55, 10'h2AA, 8'hAA, 10'h155));
        plates_to_send.push_back(make_plate(8'h80, 8'h01, 512, 8'h7F, 512));
        // fill one bucket with keys that differ in a single field each
        plates_to_send.push_back(make_plate(65, 66, 5, 67, 1));
        plates_to_send.push_back(make_plate(66, 66, 5, 67, 1));
        plates_to_send.push_back(make_plate(65, 67, 5, 67, 1));
        plates_to_send.push_back(make_plate(65, 66, 5, 68, 1));
        // bucket now full: a new key is dropped, known keys still report duplicate
        plates_to_send.push_back(make_plate(65, 66, 5, 67, 2));
        plates_to_send.push_back(make_plate(65, 66, 5, 67, 1));
        plates_to_send.push_back(make_plate(65, 66, 5, 68, 1));
        plates_to_send.push_back(make_plate(65, 66, 5, 67, 2));
        // same letters and region in a neighbor bucket is a different plate
        plates_to_send.push_back(make_plate(65, 66, 6, 67, 1));
        plates_to_send.push_back(make_plate(65, 66, 4, 67, 1));

        foreach (hot[i]) begin
            hot[i] = $urandom_range(999);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // replay an earlier plate
                p = plates_to_send[$urandom_range(plates_to_send.size() - 1)];
            end else if (pick < 70) begin
                // narrow key space on a few buckets: fills, duplicates and drops
                p = make_plate($urandom_range(66, 65), $urandom_range(66, 65),
                               hot[$urandom_range(HOT_COUNT - 1)],
                               $urandom_range(66, 65), $urandom_range(2));
            end else begin
                p = make_plate($urandom_range(255), $urandom_range(255), $urandom_range(999),
                               $urandom_range(255), $urandom_range(999));
            end
            plates_to_send.push_back(p);
        end
        n_total = plates_to_send.size();
    end

    // hold reset at start, then release it; the block then clears its counters with s_tready low
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // request driver: holds a request until taken, idles at a rate that depends on phase
    always @(negedge aclk) begin
        int unsigned idle_pct;
        idle_pct = (n_sent < n_total / 3) ? 21 : (n_sent < 2 * n_total / 3) ? 55 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_taken) begin
            // request still waiting on s_tready
        end else if (plates_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
            s_tdata  <= plates_to_send.pop_front();
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls, plus one long hold to back up the queue
    always @(negedge aclk) begin
        int unsigned idle_pct;
        int unsigned hold_left;
        logic        hold_done;
        idle_pct = (n_sent < n_total / 3) ? 55 : (n_sent < 2 * n_total / 3) ? 21 : 0;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && n_sent >= 3 * n_total / 4) begin
            // sender keeps offering while results pile up
            m_tready  <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // monitor: check results against the oldest prediction, predict each taken request
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        req_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no request pending, data", got, 0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch("status", got.status, want.status);
                    end
                    if (got.fill !== want.fill) begin
                        report_mismatch("bucket_fill", got.fill, want.fill);
                    end
                    if (got.zero !== '0) begin
                        report_mismatch("padding bits", got.zero, 0);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_verdicts.push_back(predict_insert(plate_t'(s_tdata)));
                n_sent <= n_sent + 1;
            end
        end
    end

    // end of run: all requests taken, all results in, then a short drain
    initial begin
        wait (aresetn);
        do begin
            @(negedge aclk);
        end while (n_total == 0 || plates_to_send.size() != 0 || s_tvalid
                   || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout waiting for results");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
